// ----- rtl/hrd_pkg.sv -----
package hrd_pkg;

    localparam int unsigned MAX_RESPONSE_BYTES = 262143;
    localparam int unsigned BODY_LIMIT         = 65535;
    localparam int unsigned FIFO_DEPTH         = 4;

    // Status digits sit at byte offsets 9 to 11; a response shorter than 12 is short.
    localparam int unsigned STATUS_FIRST   = 9;
    localparam int unsigned MIN_RESP_BYTES = 12;
    localparam int unsigned NEEDLE_LEN     = 26;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [23:0] CR_LF_CR = 24'h0D0A0D;

    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_SHORT      = 2'd1;
    localparam logic [1:0] ERR_NO_HDR_END = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_LINE,
        PH_DATA,
        PH_TRAIL,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_response;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [9:0]  status_code;
        logic [15:0] body_length;
        logic [1:0]  error_code;
        logic        last;
    } t_out_beat;

    // Up to two result beats produced by one input beat, in delivery order.
    typedef struct packed {
        logic [1:0] num;
        t_out_beat  beat0;
        t_out_beat  beat1;
    } t_push;

    // "transfer-encoding: chunked", lower case.
    function automatic logic [7:0] needle_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:  ch = "t";
            5'd1:  ch = "r";
            5'd2:  ch = "a";
            5'd3:  ch = "n";
            5'd4:  ch = "s";
            5'd5:  ch = "f";
            5'd6:  ch = "e";
            5'd7:  ch = "r";
            5'd8:  ch = "-";
            5'd9:  ch = "e";
            5'd10: ch = "n";
            5'd11: ch = "c";
            5'd12: ch = "o";
            5'd13: ch = "d";
            5'd14: ch = "i";
            5'd15: ch = "n";
            5'd16: ch = "g";
            5'd17: ch = ":";
            5'd18: ch = " ";
            5'd19: ch = "c";
            5'd20: ch = "h";
            5'd21: ch = "u";
            5'd22: ch = "n";
            5'd23: ch = "k";
            5'd24: ch = "e";
            5'd25: ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

endpackage

// ----- rtl/hrd_core.sv -----
module hrd_core #(
    parameter int unsigned MAX_RESPONSE_BYTES = hrd_pkg::MAX_RESPONSE_BYTES,
    parameter int unsigned BODY_LIMIT         = hrd_pkg::BODY_LIMIT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  hrd_pkg::t_in_beat i_beat,
    output hrd_pkg::t_push   o_push
);

    localparam int unsigned CNT_W  = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam int unsigned BODY_W = $clog2(BODY_LIMIT + 1);

    logic [CNT_W-1:0]  r_byte_count,  n_byte_count;
    logic [23:0]       r_recent,      n_recent;
    logic              r_header_done, n_header_done;
    logic [9:0]        r_status,      n_status;
    logic              r_status_open, n_status_open;
    logic [4:0]        r_needle_pos,  n_needle_pos;
    logic              r_chunked,     n_chunked;
    hrd_pkg::t_phase   r_phase,       n_phase;
    logic              r_size_seen,   n_size_seen;
    logic [31:0]       r_chunk_rem,   n_chunk_rem;
    logic [1:0]        r_trailer,     n_trailer;
    logic [BODY_W-1:0] r_body_count,  n_body_count;

    logic [7:0]      c;
    logic [7:0]      lc;
    logic            eor;
    logic            take;
    logic            in_chunk;
    logic            hex_ok;
    logic [3:0]      hex_val;
    logic            is_digit;
    logic            in_status;
    hrd_pkg::t_phase line_end_phase;

    assign c        = i_beat.data_byte;
    assign lc       = hrd_pkg::to_lower(c);
    assign eor      = i_accept && i_beat.end_of_response;
    assign take     = i_accept && (r_byte_count < CNT_W'(MAX_RESPONSE_BYTES));
    assign in_chunk = take && r_header_done && r_chunked;
    assign is_digit = (c >= "0") && (c <= "9");
    assign in_status = (r_byte_count >= CNT_W'(hrd_pkg::STATUS_FIRST))
                    && (r_byte_count < CNT_W'(hrd_pkg::MIN_RESP_BYTES));

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (is_digit) begin
            hex_val = 4'(c - "0");
        end else if (lc >= "a" && lc <= "f") begin
            hex_val = 4'(lc - "a" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign line_end_phase = (!r_size_seen || r_chunk_rem == 32'd0) ?
                            hrd_pkg::PH_DONE : hrd_pkg::PH_DATA;

    // Chunk framing next state
    always_comb begin
        n_phase = r_phase;
        if (in_chunk) begin
            case (r_phase)
                hrd_pkg::PH_SIZE: begin
                    if (!hex_ok) begin
                        n_phase = (c == hrd_pkg::CHAR_LF) ? line_end_phase : hrd_pkg::PH_LINE;
                    end
                end
                hrd_pkg::PH_LINE: begin
                    if (c == hrd_pkg::CHAR_LF) begin
                        n_phase = line_end_phase;
                    end
                end
                hrd_pkg::PH_DATA: begin
                    if (r_chunk_rem == 32'd1) begin
                        n_phase = hrd_pkg::PH_TRAIL;
                    end
                end
                hrd_pkg::PH_TRAIL: begin
                    if (r_trailer == 2'd1) begin
                        n_phase = hrd_pkg::PH_SIZE;
                    end
                end
                default: ;
            endcase
        end
        if (eor) begin
            n_phase = hrd_pkg::PH_SIZE;
        end
    end

    // Parser datapath and result beats
    always_comb begin
        logic offer;
        logic emit;
        hrd_pkg::t_out_beat body_beat;
        hrd_pkg::t_out_beat sum_beat;

        n_byte_count  = r_byte_count;
        n_recent      = r_recent;
        n_header_done = r_header_done;
        n_status      = r_status;
        n_status_open = r_status_open;
        n_needle_pos  = r_needle_pos;
        n_chunked     = r_chunked;
        n_size_seen   = r_size_seen;
        n_chunk_rem   = r_chunk_rem;
        n_trailer     = r_trailer;
        n_body_count  = r_body_count;

        offer = take && r_header_done && (!r_chunked || r_phase == hrd_pkg::PH_DATA);
        emit  = offer && (r_body_count < BODY_W'(BODY_LIMIT));

        if (take) begin
            n_byte_count = r_byte_count + CNT_W'(1);
            n_recent     = {r_recent[15:0], c};
            if (in_status) begin
                if (r_status_open && is_digit) begin
                    n_status = 10'(r_status * 10'd10) + 10'(c - "0");
                end else begin
                    n_status_open = 1'b0;
                end
            end
            if (!r_header_done) begin
                if (lc == hrd_pkg::needle_char(r_needle_pos)) begin
                    if (r_needle_pos == 5'(hrd_pkg::NEEDLE_LEN - 1)) begin
                        n_chunked    = 1'b1;
                        n_needle_pos = 5'd0;
                    end else begin
                        n_needle_pos = r_needle_pos + 5'd1;
                    end
                end else begin
                    n_needle_pos = (lc == "t") ? 5'd1 : 5'd0;
                end
                if (c == hrd_pkg::CHAR_LF && r_recent == hrd_pkg::CR_LF_CR) begin
                    n_header_done = 1'b1;
                end
            end
        end

        if (in_chunk) begin
            case (r_phase)
                hrd_pkg::PH_SIZE: begin
                    if (hex_ok) begin
                        // saturate the size accumulator at all ones
                        n_chunk_rem = (r_chunk_rem[31:28] != 4'd0) ? 32'hFFFF_FFFF
                                                                  : {r_chunk_rem[27:0], hex_val};
                        n_size_seen = 1'b1;
                    end
                end
                hrd_pkg::PH_DATA: begin
                    n_chunk_rem = r_chunk_rem - 32'd1;
                    if (r_chunk_rem == 32'd1) begin
                        n_trailer = 2'd2;
                    end
                end
                hrd_pkg::PH_TRAIL: begin
                    n_trailer = r_trailer - 2'd1;
                    if (r_trailer == 2'd1) begin
                        n_size_seen = 1'b0;
                        n_chunk_rem = 32'd0;
                    end
                end
                default: ;
            endcase
        end

        if (emit) begin
            n_body_count = r_body_count + BODY_W'(1);
        end

        body_beat             = '0;
        body_beat.kind        = hrd_pkg::KIND_BODY;
        body_beat.body_byte   = c;

        sum_beat              = '0;
        sum_beat.kind         = hrd_pkg::KIND_SUMMARY;
        sum_beat.status_code  = n_status;
        sum_beat.body_length  = (32'(n_body_count) > 32'hFFFF) ? 16'hFFFF : 16'(n_body_count);
        sum_beat.last         = 1'b1;
        if (n_byte_count < CNT_W'(hrd_pkg::MIN_RESP_BYTES)) begin
            sum_beat.error_code = hrd_pkg::ERR_SHORT;
        end else if (!n_header_done) begin
            sum_beat.error_code = hrd_pkg::ERR_NO_HDR_END;
        end else begin
            sum_beat.error_code = hrd_pkg::ERR_OK;
        end

        o_push.num   = 2'(emit) + 2'(eor);
        o_push.beat0 = emit ? body_beat : sum_beat;
        o_push.beat1 = sum_beat;

        // return to reset state after the summary
        if (eor) begin
            n_byte_count  = '0;
            n_recent      = '0;
            n_header_done = 1'b0;
            n_status      = '0;
            n_status_open = 1'b1;
            n_needle_pos  = '0;
            n_chunked     = 1'b0;
            n_size_seen   = 1'b0;
            n_chunk_rem   = '0;
            n_trailer     = '0;
            n_body_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_recent      <= '0;
            r_header_done <= 1'b0;
            r_status      <= '0;
            r_status_open <= 1'b1;
            r_needle_pos  <= '0;
            r_chunked     <= 1'b0;
            r_phase       <= hrd_pkg::PH_SIZE;
            r_size_seen   <= 1'b0;
            r_chunk_rem   <= '0;
            r_trailer     <= '0;
            r_body_count  <= '0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_recent      <= n_recent;
            r_header_done <= n_header_done;
            r_status      <= n_status;
            r_status_open <= n_status_open;
            r_needle_pos  <= n_needle_pos;
            r_chunked     <= n_chunked;
            r_phase       <= n_phase;
            r_size_seen   <= n_size_seen;
            r_chunk_rem   <= n_chunk_rem;
            r_trailer     <= n_trailer;
            r_body_count  <= n_body_count;
        end
    end

endmodule

// ----- rtl/hrd_fifo.sv -----
module hrd_fifo #(
    parameter int unsigned FIFO_DEPTH = hrd_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hrd_pkg::t_push                    i_push,
    input  logic                              i_pop,
    output hrd_pkg::t_out_beat                o_head,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   o_count
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    hrd_pkg::t_out_beat r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [PTR_W-1:0]   wr_ptr_1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ptr_1 = ptr_inc(r_wr_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        case (i_push.num)
            2'd1:    n_wr_ptr = wr_ptr_1;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr_1);
            default: ;
        endcase
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.num) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.beat0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- rtl/http_response_dechunker_unit.sv -----
// Result beats go into the registered result queue and are offered from its head.
// Throughput: one input beat per cycle when not stalled; a final byte that also
// yields a body byte queues two result beats, drained one per unstalled cycle.
// Input stalls while the result queue has fewer than two free entries.
// Reset: synchronous, active low; clears the parser and empties the queue.
// Parser state also returns to its reset values after every summary beat.
module http_response_dechunker_unit #(
    parameter int unsigned MAX_RESPONSE_BYTES = hrd_pkg::MAX_RESPONSE_BYTES,
    parameter int unsigned BODY_LIMIT         = hrd_pkg::BODY_LIMIT,
    parameter int unsigned FIFO_DEPTH         = hrd_pkg::FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hrd_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hrd_pkg::t_out_beat o_out_beat
);

    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             in_accept;
    logic             out_accept;
    hrd_pkg::t_push   push;
    logic [CNT_W-1:0] fifo_count;

    assign o_in_stall  = fifo_count > CNT_W'(FIFO_DEPTH - 2);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = fifo_count != '0;
    assign out_accept  = o_out_valid && !i_out_stall;

    hrd_core #(
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES),
        .BODY_LIMIT         (BODY_LIMIT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_beat),
        .o_push   (push)
    );

    hrd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_accept),
        .o_head  (o_out_beat),
        .o_count (fifo_count)
    );

`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue over capacity");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> fifo_count <= CNT_W'(FIFO_DEPTH - 2))
        else $error("input beat taken without room for two results");

    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_beat.end_of_response) |=> o_out_valid)
        else $error("end of response produced no result");

    a_body_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.kind == hrd_pkg::KIND_BODY)
            |-> (!o_out_beat.last && o_out_beat.error_code == hrd_pkg::ERR_OK))
        else $error("body beat carries summary fields");
`endif

endmodule

// ----- sim/hrd_checker.sv -----
module hrd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  hrd_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  hrd_pkg::t_out_beat i_out_beat,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending,
    output int unsigned        o_body_beats,
    output int unsigned        o_summaries
);

    localparam logic [8*hrd_pkg::NEEDLE_LEN-1:0] CHUNKED_TAG = "transfer-encoding: chunked";

    // Shadow parser state
    logic [17:0]     rx_count;
    logic [23:0]     last_three;
    logic            hdr_done;
    logic [9:0]      status_acc;
    logic            status_live;
    logic [4:0]      tag_pos;
    logic            chunked;
    hrd_pkg::t_phase phase;
    logic            size_valid;
    logic [31:0]     chunk_left;
    logic [1:0]      crlf_left;
    logic [15:0]     emitted;

    hrd_pkg::t_out_beat expected_beats[$];

    int unsigned fail_count    = 0;
    int unsigned pending_beats = 0;
    int unsigned body_beats    = 0;
    int unsigned summaries     = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_beats;
    assign o_body_beats = body_beats;
    assign o_summaries  = summaries;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] v;
        lc = fold_case(c);
        v  = lc - "a" + 8'd10;
        if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
        if (lc >= "a" && lc <= "f") return {1'b1, v[3:0]};
        return 5'd0;
    endfunction

    function automatic hrd_pkg::t_phase after_size_line();
        return (!size_valid || chunk_left == 32'd0) ? hrd_pkg::PH_DONE : hrd_pkg::PH_DATA;
    endfunction

    task automatic clear_parser();
        rx_count    = '0;
        last_three  = '0;
        hdr_done    = 1'b0;
        status_acc  = '0;
        status_live = 1'b1;
        tag_pos     = '0;
        chunked     = 1'b0;
        phase       = hrd_pkg::PH_SIZE;
        size_valid  = 1'b0;
        chunk_left  = '0;
        crlf_left   = '0;
        emitted     = '0;
    endtask

    task automatic offer_body(input logic [7:0] c);
        hrd_pkg::t_out_beat beat;
        if (emitted < hrd_pkg::BODY_LIMIT) begin
            emitted        = emitted + 16'd1;
            beat           = '0;
            beat.kind      = hrd_pkg::KIND_BODY;
            beat.body_byte = c;
            expected_beats.push_back(beat);
        end
    endtask

    task automatic decode_byte(input hrd_pkg::t_in_beat b);
        logic [7:0]         c;
        logic [4:0]         hv;
        logic [35:0]        acc;
        hrd_pkg::t_out_beat sum;
        c = b.data_byte;
        if (rx_count < hrd_pkg::MAX_RESPONSE_BYTES) begin
            if (rx_count >= hrd_pkg::STATUS_FIRST && rx_count < hrd_pkg::MIN_RESP_BYTES) begin
                if (status_live && c >= "0" && c <= "9") begin
                    status_acc = status_acc * 10'd10 + {2'b00, c - "0"};
                end else begin
                    status_live = 1'b0;
                end
            end
            rx_count = rx_count + 18'd1;
            if (hdr_done && !chunked) begin
                offer_body(c);
            end else if (hdr_done) begin
                case (phase)
                    hrd_pkg::PH_SIZE: begin
                        hv = hex_value(c);
                        if (hv[4]) begin
                            acc        = {chunk_left, 4'h0} + hv[3:0];
                            chunk_left = (acc[35:32] != 4'h0) ? 32'hFFFF_FFFF : acc[31:0];
                            size_valid = 1'b1;
                        end else if (c == hrd_pkg::CHAR_LF) begin
                            phase = after_size_line();
                        end else begin
                            phase = hrd_pkg::PH_LINE;
                        end
                    end
                    hrd_pkg::PH_LINE: begin
                        if (c == hrd_pkg::CHAR_LF) phase = after_size_line();
                    end
                    hrd_pkg::PH_DATA: begin
                        offer_body(c);
                        chunk_left = chunk_left - 32'd1;
                        if (chunk_left == 32'd0) begin
                            phase     = hrd_pkg::PH_TRAIL;
                            crlf_left = 2'd2;
                        end
                    end
                    hrd_pkg::PH_TRAIL: begin
                        crlf_left = crlf_left - 2'd1;
                        if (crlf_left == 2'd0) begin
                            phase      = hrd_pkg::PH_SIZE;
                            size_valid = 1'b0;
                            chunk_left = '0;
                        end
                    end
                    default: ;
                endcase
            end else begin
                if (fold_case(c) == CHUNKED_TAG[8*(hrd_pkg::NEEDLE_LEN-1-tag_pos) +: 8]) begin
                    if (tag_pos == hrd_pkg::NEEDLE_LEN - 1) begin
                        chunked = 1'b1;
                        tag_pos = '0;
                    end else begin
                        tag_pos = tag_pos + 5'd1;
                    end
                end else begin
                    // A 't' may open a fresh match.
                    tag_pos = {4'd0, fold_case(c) == "t"};
                end
                if (c == hrd_pkg::CHAR_LF && last_three == hrd_pkg::CR_LF_CR) hdr_done = 1'b1;
            end
            last_three = {last_three[15:0], c};
        end
        if (b.end_of_response) begin
            sum             = '0;
            sum.kind        = hrd_pkg::KIND_SUMMARY;
            sum.status_code = status_acc;
            sum.body_length = emitted;
            sum.error_code  = (rx_count < hrd_pkg::MIN_RESP_BYTES) ? hrd_pkg::ERR_SHORT :
                              (!hdr_done ? hrd_pkg::ERR_NO_HDR_END : hrd_pkg::ERR_OK);
            sum.last        = 1'b1;
            expected_beats.push_back(sum);
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        hrd_pkg::t_out_beat want;
        if (!i_rst_n) begin
            clear_parser();
            expected_beats.delete();
        end else begin
            // Compare before predicting: a beat leaving now is never caused by a beat
            // entering now.
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat %h with nothing expected", i_out_beat);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", want.kind, i_out_beat.kind);
                    check_field("body_byte", want.body_byte, i_out_beat.body_byte);
                    check_field("status_code", want.status_code, i_out_beat.status_code);
                    check_field("body_length", want.body_length, i_out_beat.body_length);
                    check_field("error_code", want.error_code, i_out_beat.error_code);
                    check_field("last", want.last, i_out_beat.last);
                    if (want.kind == hrd_pkg::KIND_SUMMARY) summaries++;
                    else body_beats++;
                end
            end
            if (i_in_valid && !i_in_stall) decode_byte(i_in_beat);
        end
        pending_beats <= expected_beats.size();
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    hrd_pkg::t_in_beat  in_beat   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    hrd_pkg::t_out_beat out_beat;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned responses     = 0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned body_beats;
    int unsigned summaries;

    http_response_dechunker_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    hrd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_body_beats (body_beats),
        .o_summaries  (summaries)
    );

    always #5 clk = ~clk;

    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endtask

    task automatic add_line(ref logic [7:0] q[$], input string s);
        add_text(q, s);
        q.push_back(8'h0D);
        q.push_back(hrd_pkg::CHAR_LF);
    endtask

    // Hex size in random case, sometimes zero-padded or with an extension.
    task automatic add_chunk_size(ref logic [7:0] q[$], input int unsigned size);
        string s;
        s = $sformatf("%0h", size);
        if ($urandom_range(7) == 0) q.push_back("0");
        for (int i = 0; i < s.len(); i++) begin
            q.push_back((s[i] >= "a" && $urandom_range(1) == 1) ? s[i] - 8'd32 : s[i]);
        end
        if ($urandom_range(4) == 0) add_text(q, ";ext=1");
        add_line(q, "");
    endtask

    task automatic add_random_bytes(ref logic [7:0] q[$], input int unsigned n);
        repeat (n) q.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_beat(input logic [7:0] b, input logic eor);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{data_byte: b, end_of_response: eor};
        do @(posedge clk); while (in_stall);
        if (eor) responses++;
    endtask

    task automatic send_bytes(ref logic [7:0] q[$], input bit mark_end);
        for (int i = 0; i < q.size(); i++) send_beat(q[i], mark_end && i == q.size() - 1);
    endtask

    task automatic add_chunked_header(ref logic [7:0] q[$]);
        add_line(q, "HTTP/1.1 200 OK");
        add_line(q, "Transfer-Encoding: chunked");
        add_line(q, "");
    endtask

    task automatic run_directed();
        logic [7:0] q[$];
        // lone byte carrying the end mark
        q = {8'hFF};
        send_bytes(q, 1);
        // one byte short of the status field
        q.delete(); add_text(q, "HTTP/1.1 20");
        send_bytes(q, 1);
        // exactly long enough, but no header end
        q.delete(); add_text(q, "HTTP/1.1 200");
        send_bytes(q, 1);
        // header end at the very start, then short
        q.delete(); add_line(q, ""); add_line(q, ""); add_text(q, "AB");
        send_bytes(q, 1);
        // non-digit inside the status, headers never closed
        q.delete(); add_line(q, "HTTP/1.1 2x4 Bad"); add_line(q, "Server: x");
        send_bytes(q, 1);
        // plain body with extreme byte values
        q.delete(); add_line(q, "HTTP/1.1 404 Not Found"); add_line(q, "");
        q.push_back(8'h00); q.push_back(8'hFF); q.push_back(8'h80); q.push_back(8'h7F);
        send_bytes(q, 1);
        // mixed-case tag, extension, trailing junk after the last chunk
        q.delete(); add_line(q, "HTTP/1.1 200 OK"); add_line(q, "TRANSFER-Encoding: Chunked");
        add_line(q, ""); add_line(q, "A;name=val"); add_text(q, "0123456789"); add_line(q, "");
        add_line(q, "f"); add_text(q, "abcdefghijklmno"); add_line(q, "");
        add_line(q, "0"); add_line(q, ""); add_text(q, "junk");
        send_bytes(q, 1);
        // doubled 't' restarts the tag match; bare LF as an empty size line
        q.delete(); add_line(q, "HTTP/1.1 201 OK"); add_line(q, "Xttransfer-encoding: chunked");
        add_line(q, ""); add_line(q, "3"); add_text(q, "abc"); add_line(q, "");
        q.push_back(hrd_pkg::CHAR_LF); add_line(q, "5"); add_text(q, "hello");
        send_bytes(q, 1);
        // size line without a hex digit ends decoding
        q.delete(); add_chunked_header(q); add_line(q, "zz"); add_line(q, "4"); add_text(q, "abcd");
        send_bytes(q, 1);
        // saturating chunk size
        q.delete(); add_chunked_header(q); add_line(q, "fffffffff0"); add_text(q, "hello");
        send_bytes(q, 1);
        // status extremes
        q.delete(); add_line(q, "HTTP/1.1 999 X"); add_line(q, ""); add_text(q, "b");
        send_bytes(q, 1);
        q.delete(); add_line(q, "HTTP/1.1 000 X"); add_line(q, "");
        send_bytes(q, 1);
    endtask

    task automatic make_random_response(ref logic [7:0] q[$]);
        string tag;
        int unsigned style;
        bit use_chunks;
        q.delete();
        style = $urandom_range(99);
        if (style < 8) begin
            add_random_bytes(q, $urandom_range(1, 30));
            return;
        end
        add_text(q, "HTTP/1.1 ");
        repeat (3) q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                       : 8'("0" + $urandom_range(9)));
        add_line(q, " OK");
        repeat ($urandom_range(2)) add_line(q, "X-Hdr: v");
        use_chunks = 1'($urandom_range(1));
        if (use_chunks) begin
            tag = "transfer-encoding: chunked";
            if ($urandom_range(7) == 0) tag[$urandom_range(tag.len() - 1)] = "x";
            if ($urandom_range(7) == 0) tag = {"t", tag};
            for (int i = 0; i < tag.len(); i++) begin
                q.push_back((tag[i] >= "a" && tag[i] <= "z" && $urandom_range(1) == 1)
                            ? tag[i] - 8'd32 : tag[i]);
            end
            add_line(q, "");
        end
        if ($urandom_range(1) == 1) add_line(q, "Server: y");
        add_line(q, "");
        if (use_chunks) begin
            repeat ($urandom_range(3)) begin
                int unsigned n;
                n = $urandom_range(1, 24);
                add_chunk_size(q, n);
                add_random_bytes(q, n);
                add_line(q, "");
            end
            style = $urandom_range(9);
            if (style < 8) begin
                add_line(q, "0");
                add_line(q, "");
            end else if (style == 8) begin
                add_line(q, "");
            end
            if ($urandom_range(3) == 0) add_random_bytes(q, $urandom_range(1, 8));
        end else begin
            add_random_bytes(q, $urandom_range(40));
        end
        // cut some responses short anywhere
        if ($urandom_range(99) < 15) begin
            int unsigned keep;
            keep = $urandom_range(1, q.size());
            while (q.size() > keep) void'(q.pop_back());
        end
    endtask

    initial begin : stimulus
        logic [7:0] q[$];
        int unsigned sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 7 : ((mode == 1) ? 61 : 0);
            recv_idle_pct = (mode == 0) ? 61 : ((mode == 1) ? 7 : 0);
            if (mode == 0) run_directed();
            sent = 0;
            while (sent < 350) begin
                make_random_response(q);
                sent += q.size();
                send_bytes(q, 1);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Ran %0d responses; %0d body beats and %0d summaries matched the prediction.",
                 responses, body_beats, summaries);
        $display("Included short, unterminated, plain, chunked and saturating-size responses.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
